// ===== hdl/dlar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlar_pkg
// Types, codes and constants shared by the display-list address relocator.
// ----------------------------------------------------------------------------
package dlar_pkg;

    localparam int DEF_TEXTURE_ENTRIES = 64;
    localparam int CFG_INDEX_W         = 8;
    localparam int CFG_DATA_W          = 32;
    localparam int OFFSET_W            = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_VERTEX_BASE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_VERTEX_BASE = CFG_INDEX_W'(1);

    localparam logic [7:0] OP_VTX      = 8'h01;
    localparam logic [7:0] OP_OP03     = 8'h03;
    localparam logic [7:0] OP_OP04     = 8'h04;
    localparam logic [7:0] OP_OP06     = 8'h06;
    localparam logic [7:0] OP_OP07     = 8'h07;
    localparam logic [7:0] OP_END_LIST = 8'hb8;
    localparam logic [7:0] OP_OPBC     = 8'hbc;
    localparam logic [7:0] OP_SET_TIMG = 8'hfd;
    localparam logic [7:0] OP_OPFE     = 8'hfe;
    localparam logic [7:0] OP_OPFF     = 8'hff;

    localparam logic [3:0] SEG_VERTEX = 4'h5;

    typedef enum logic [1:0] {
        CMD_REWRITE = 2'd0,
        CMD_ADD_MAP = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BELOW = 2'd1,
        STATUS_NOTEX = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [31:0]         first_word;
        logic [31:0]         second_word;
        logic [OFFSET_W-1:0] map_source;
        logic [OFFSET_W-1:0] map_target;
    } request_t;

    typedef struct packed {
        logic [31:0] rewritten_word;
        status_t     status;
        logic        end_of_list;
    } result_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] source;
        logic [OFFSET_W-1:0] target;
    } map_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_req;
        logic hit;
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== hdl/dlar_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlar_ctrl
// Sequencer: accepts a transfer, runs the table scan if needed, then finishes.
// ----------------------------------------------------------------------------
module dlar_ctrl
    import dlar_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.search_req)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_finish_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish)
        else $error("finish held for more than one cycle");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("load did not start execution");
`endif

endmodule

// ===== hdl/dlar_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlar_datapath
// Request capture, base registers, texture table memory, scan and result.
// ----------------------------------------------------------------------------
module dlar_datapath
    import dlar_pkg::*;
#(
    parameter int TEXTURE_ENTRIES = DEF_TEXTURE_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  request_t               request,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    output result_t                result,
    output logic                   done
);

    localparam int IDX_W = (TEXTURE_ENTRIES > 1) ? $clog2(TEXTURE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TEXTURE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TEXTURE_ENTRIES);

    request_t            req_reg;
    request_t            req_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic                cmp_valid_reg;
    logic                cmp_valid_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [OFFSET_W-1:0] src_base_reg;
    logic [OFFSET_W-1:0] src_base_next;
    logic [OFFSET_W-1:0] dst_base_reg;
    logic [OFFSET_W-1:0] dst_base_next;
    result_t             result_reg;
    result_t             result_next;
    logic                done_reg;
    logic                done_next;
    map_entry_t          rd_data_reg;
    logic                mem_we;

    map_entry_t          mem [TEXTURE_ENTRIES];

    logic [7:0]          op;
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] new_off;
    logic                relocate;
    logic                segmented;

    assign op  = req_reg.first_word[31:24];
    assign off = req_reg.second_word[OFFSET_W-1:0];
    assign relocate = ((op == OP_OP04) || (op == OP_OP07) || (op == OP_OPBC) ||
                       (op == OP_SET_TIMG)) && (req_reg.second_word[27:24] == SEG_VERTEX);
    assign segmented = (op == OP_VTX) || (op == OP_OP03) || (op == OP_OP04) ||
                       (op == OP_OP06) || (op == OP_OP07) || (op == OP_SET_TIMG) ||
                       (op == OP_OPFE) || (op == OP_OPFF);

    assign stat.search_req = (req_reg.cmd == CMD_REWRITE) && relocate && (op == OP_SET_TIMG);
    assign stat.hit        = cmp_valid_reg && (rd_data_reg.source == off);
    assign stat.scan_done  = !cmp_valid_reg && (idx_reg == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            src_base_reg  <= '0;
            dst_base_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            src_base_reg  <= src_base_next;
            dst_base_reg  <= dst_base_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{source: req_reg.map_source,
                                           target: req_reg.map_target};
        end
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        src_base_next = src_base_reg;
        dst_base_next = dst_base_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_SRC_VERTEX_BASE)
            begin
                src_base_next = cfg_data[OFFSET_W-1:0];
            end
            else if (cfg_index == CFG_DST_VERTEX_BASE)
            begin
                dst_base_next = cfg_data[OFFSET_W-1:0];
            end
        end
    end

    always_comb
    begin
        req_next       = req_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        count_next     = count_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        new_off        = off;

        if (cmd.load)
        begin
            req_next       = request;
            idx_next       = '0;
            cmp_valid_next = 1'b0;
        end

        if (cmd.scan)
        begin
            if (idx_reg != count_reg)
            begin
                idx_next       = idx_reg + CNT_W'(1);
                cmp_valid_next = 1'b1;
            end
            else
            begin
                cmp_valid_next = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            done_next   = 1'b1;
            result_next = '{rewritten_word: '0, status: STATUS_OK, end_of_list: 1'b0};
            unique case (req_reg.cmd)
                CMD_REWRITE:
                begin
                    result_next.rewritten_word = req_reg.second_word;
                    if (relocate)
                    begin
                        if (op == OP_SET_TIMG)
                        begin
                            if (stat.hit)
                            begin
                                new_off = rd_data_reg.target;
                            end
                            else
                            begin
                                new_off            = '0;
                                result_next.status = STATUS_NOTEX;
                            end
                        end
                        else if (off < src_base_reg)
                        begin
                            result_next.status = STATUS_BELOW;
                        end
                        else
                        begin
                            new_off = off - src_base_reg + dst_base_reg;
                        end
                        result_next.rewritten_word[OFFSET_W-1:0] = new_off;
                    end
                    if (segmented)
                    begin
                        result_next.rewritten_word[0] = 1'b1;
                    end
                    result_next.end_of_list = (op == OP_END_LIST);
                end
                CMD_ADD_MAP:
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next.status = STATUS_FULL;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                CMD_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (idx_reg <= count_reg))
        else $error("scan index ran past the fill count");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("fill count above table depth");
`endif

endmodule

// ===== hdl/display_list_address_relocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_list_address_relocator
// Relocates segment-five addresses in display-list commands; texture table.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. Its result appears
// on result for exactly one cycle with done high and must be captured then.
// Inserts, clears and non-texture commands hold busy only for the execute
// state, which registers the result and done. A texture command (0xFD,
// segment 5) scans the table one entry per cycle through the memory read
// port, and busy stays high until a hit or the end of the filled entries.
// Busy drops as the result is registered, so the next transfer may be taken
// while done is shown. cfg_ready is always high; write configuration only
// while idle.
// ----------------------------------------------------------------------------
module display_list_address_relocator
    import dlar_pkg::*;
#(
    parameter int TEXTURE_ENTRIES = DEF_TEXTURE_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               request,
    output result_t                result,
    output logic                   done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    dlar_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (dp_cmd),
        .busy  (busy)
    );

    dlar_datapath #(
        .TEXTURE_ENTRIES (TEXTURE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .result    (result),
        .done      (done)
    );

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transfer in flight");
`endif

endmodule

// ===== tb/sv/display_list_address_relocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_list_address_relocator_test
// Self-checking bench for the display-list relocator. A queue of commands,
// directed and random, is driven in bursts with random gaps. A local copy of
// the texture table and vertex bases predicts every result, and a monitor
// compares each strobed result field by field, in order.
// ----------------------------------------------------------------------------
module display_list_address_relocator_test;
    import dlar_pkg::*;

    localparam int TEXTURE_ENTRIES = DEF_TEXTURE_ENTRIES;
    localparam logic [7:0] OPCODE_POOL [11] = '{OP_OP04, OP_OP07, OP_OPBC, OP_SET_TIMG,
        OP_SET_TIMG, OP_END_LIST, OP_VTX, OP_OP03, OP_OP06, OP_OPFE, OP_OPFF};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    request_t               request = '0;
    result_t                result;
    logic                   done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [OFFSET_W-1:0] model_src_base = '0;
    logic [OFFSET_W-1:0] model_dst_base = '0;
    logic [OFFSET_W-1:0] model_sources [TEXTURE_ENTRIES];
    logic [OFFSET_W-1:0] model_targets [TEXTURE_ENTRIES];
    int                  model_count = 0;

    request_t            command_queue [$];
    result_t             expected_results [$];
    logic [OFFSET_W-1:0] known_sources [$];
    result_t             expected_now;
    int                  mismatch_count = 0;
    int                  burst_left = 1;
    int                  gap_left = 0;
    bit                  took;

    display_list_address_relocator #(
        .TEXTURE_ENTRIES (TEXTURE_ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .result    (result),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t predict_relocation(request_t req);
        result_t             r;
        logic [7:0]          op;
        logic [OFFSET_W-1:0] off;
        logic [OFFSET_W-1:0] new_off;
        bit                  hit;
        r = '0;
        r.status = STATUS_OK;
        case (req.cmd)
            CMD_REWRITE:
            begin
                op = req.first_word[31:24];
                r.rewritten_word = req.second_word;
                if (op inside {OP_OP04, OP_OP07, OP_OPBC, OP_SET_TIMG} &&
                    req.second_word[27:24] == SEG_VERTEX)
                begin
                    off = req.second_word[23:0];
                    new_off = off;
                    if (op == OP_SET_TIMG)
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < model_count; i++)
                        begin
                            if (!hit && model_sources[i] == off)
                            begin
                                new_off = model_targets[i];
                                hit = 1'b1;
                            end
                        end
                        if (!hit)
                        begin
                            new_off = '0;
                            r.status = STATUS_NOTEX;
                        end
                    end
                    else if (off < model_src_base)
                        r.status = STATUS_BELOW;
                    else
                        new_off = off - model_src_base + model_dst_base;
                    r.rewritten_word[23:0] = new_off;
                end
                if (op inside {OP_VTX, OP_OP03, OP_OP04, OP_OP06, OP_OP07, OP_SET_TIMG,
                               OP_OPFE, OP_OPFF})
                    r.rewritten_word[0] = 1'b1;
                r.end_of_list = (op == OP_END_LIST);
            end
            CMD_ADD_MAP:
            begin
                if (model_count < TEXTURE_ENTRIES)
                begin
                    model_sources[model_count] = req.map_source;
                    model_targets[model_count] = req.map_target;
                    model_count++;
                end
                else
                    r.status = STATUS_FULL;
            end
            CMD_CLEAR:
                model_count = 0;
            default:
                ;
        endcase
        return r;
    endfunction

    // driver: sample the handshake at the rising edge, drive at the falling edge
    always @(posedge clk)
    begin
        took = rst_n && start && !busy;
        if (took)
            expected_results.push_back(predict_relocation(request));
        @(negedge clk);
        if (rst_n && (!start || took))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (command_queue.size() > 0)
            begin
                request <= command_queue.pop_front();
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 20);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                expected_now = expected_results.pop_front();
                if (result.rewritten_word !== expected_now.rewritten_word)
                begin
                    $display("%0t: rewritten_word mismatch: expected %h, actual %h", $time,
                             expected_now.rewritten_word, result.rewritten_word);
                    mismatch_count++;
                end
                if (result.status !== expected_now.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             expected_now.status, result.status);
                    mismatch_count++;
                end
                if (result.end_of_list !== expected_now.end_of_list)
                begin
                    $display("%0t: end_of_list mismatch: expected %b, actual %b", $time,
                             expected_now.end_of_list, result.end_of_list);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic request_t make_request(cmd_t c, logic [31:0] w0, logic [31:0] w1,
                                              logic [23:0] src, logic [23:0] tgt);
        request_t r;
        r.cmd = c;
        r.first_word = w0;
        r.second_word = w1;
        r.map_source = src;
        r.map_target = tgt;
        return r;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_SRC_VERTEX_BASE)
            model_src_base = data[23:0];
        else if (idx == CFG_DST_VERTEX_BASE)
            model_dst_base = data[23:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_idle();
        while (command_queue.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_add(logic [23:0] src, logic [23:0] tgt);
        command_queue.push_back(make_request(CMD_ADD_MAP, $urandom, $urandom, src, tgt));
        known_sources.push_back(src);
    endtask

    // clear, fill the table past capacity
    task automatic queue_table_fill(int extra);
        logic [23:0] src;
        command_queue.push_back(make_request(CMD_CLEAR, $urandom, $urandom,
                                             24'($urandom), 24'($urandom)));
        known_sources.delete();
        for (int i = 0; i < TEXTURE_ENTRIES + extra; i++)
        begin
            if (known_sources.size() > 0 && $urandom_range(0, 7) == 0)
                src = known_sources[$urandom_range(0, known_sources.size() - 1)];
            else
                src = 24'($urandom);
            queue_add(src, 24'($urandom));
        end
    endtask

    task automatic queue_random_items(int count);
        int          pick;
        logic [7:0]  op;
        logic [3:0]  seg;
        logic [23:0] off;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                pick = $urandom_range(0, 12);
                op = (pick < 11) ? OPCODE_POOL[pick] : 8'($urandom);
                seg = ($urandom_range(0, 4) == 0) ? 4'($urandom) : SEG_VERTEX;
                if (op == OP_SET_TIMG)
                begin
                    if (known_sources.size() > 0 && $urandom_range(0, 9) < 7)
                        off = known_sources[$urandom_range(0, known_sources.size() - 1)];
                    else
                        off = 24'($urandom);
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0: off = model_src_base - 24'd1;
                        1: off = model_src_base;
                        2: off = model_src_base + 24'($urandom_range(0, 255));
                        3: off = '0;
                        4: off = '1;
                        default: off = 24'($urandom);
                    endcase
                end
                command_queue.push_back(make_request(CMD_REWRITE, {op, 24'($urandom)},
                    {4'($urandom), seg, off}, 24'($urandom), 24'($urandom)));
            end
            else if (pick < 88)
            begin
                if (known_sources.size() > 0 && $urandom_range(0, 3) == 0)
                    queue_add(known_sources[$urandom_range(0, known_sources.size() - 1)],
                              24'($urandom));
                else
                    queue_add(24'($urandom), 24'($urandom));
            end
            else if (pick < 93)
            begin
                command_queue.push_back(make_request(CMD_CLEAR, $urandom, $urandom,
                                                     24'($urandom), 24'($urandom)));
                known_sources.delete();
            end
            else if (pick < 96)
                command_queue.push_back(make_request(CMD_NONE, $urandom, $urandom,
                                                     24'($urandom), 24'($urandom)));
            else
                command_queue.push_back(make_request(CMD_REWRITE, $urandom, $urandom,
                                                     24'($urandom), 24'($urandom)));
        end
    endtask

    task automatic run_phase(logic [23:0] src_base, logic [23:0] dst_base, bit fill, int count);
        if ($urandom_range(0, 1) == 0)
            write_register(CFG_INDEX_W'($urandom_range(2, 255)), $urandom);
        write_register(CFG_SRC_VERTEX_BASE, {8'($urandom), src_base});
        write_register(CFG_DST_VERTEX_BASE, {8'($urandom), dst_base});
        if (fill)
            queue_table_fill($urandom_range(1, 6));
        queue_random_items(count);
        wait_for_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table, zero bases
        command_queue.push_back(make_request(CMD_REWRITE, 32'hfd000000, 32'h05123456, '0, '0));
        command_queue.push_back(make_request(CMD_ADD_MAP, 32'h0, 32'h0, 24'h000000, 24'habcdef));
        command_queue.push_back(make_request(CMD_ADD_MAP, 32'h0, 32'h0, 24'hffffff, 24'h000001));
        command_queue.push_back(make_request(CMD_ADD_MAP, 32'h0, 32'h0, 24'h123456, 24'h111111));
        command_queue.push_back(make_request(CMD_ADD_MAP, 32'h0, 32'h0, 24'h123456, 24'h222222));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hfdffffff, 32'h05123456, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hfd000000, 32'hf5ffffff, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hfd000000, 32'h04123456, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hfd000000, 32'h05000000, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'h04000000, 32'h0500abcd, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hb8ffffff, 32'hffffffff, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, {OP_VTX, 24'h0}, 32'h0, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, {OP_OP03, 24'h0}, 32'h0, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, {OP_OP06, 24'h0}, 32'h0, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, {OP_OPFE, 24'h0}, 32'h0, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, {OP_OPFF, 24'h0}, 32'h0, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'h00000000, 32'hfffffffe, '0, '0));
        command_queue.push_back(make_request(CMD_NONE, '1, '1, '1, '1));
        command_queue.push_back(make_request(CMD_CLEAR, '1, '1, '1, '1));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hfd000000, 32'h05123456, '0, '0));
        wait_for_idle();

        // offset below base, at base, and wrapping past the top
        write_register(CFG_SRC_VERTEX_BASE, 32'hff100000);
        write_register(CFG_DST_VERTEX_BASE, 32'h00f80000);
        command_queue.push_back(make_request(CMD_REWRITE, 32'h04000000, 32'h050fffff, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'h07000000, 32'ha5100000, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hbc000000, 32'h05ffffff, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'hbcffffff, 32'h15abcdef, '0, '0));
        command_queue.push_back(make_request(CMD_REWRITE, 32'h04123456, 32'h06abcdef, '0, '0));
        wait_for_idle();

        run_phase(24'h000000, 24'h000000, 1'b1, 105);
        run_phase(24'hffffff, 24'hffffff, 1'b0, 105);
        run_phase(24'h000000, 24'hffffff, 1'b1, 105);
        run_phase(24'hffffff, 24'h000000, 1'b0, 105);
        run_phase(24'h800000, 24'h7fffff, 1'b1, 105);
        for (int p = 0; p < 4; p++)
            run_phase(24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)), 105);

        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
